>>> rtl/lpd_pkg.sv
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants for the length-prefixed pair deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

  // One type byte followed by a four-byte big-endian payload length.
  localparam int unsigned HeaderBytes = 5;
  localparam int unsigned HdrIdxW     = 3;
  localparam int unsigned LenW        = 32;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_TOO_SHORT    = 2'd1,
    ST_LEN_MISMATCH = 2'd2,
    ST_NO_SEP       = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_message;
  } msg_beat_t;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] payload_byte;
    logic       second_part;
    logic [7:0] message_type;
    logic       frame_end;
    status_t    status;
  } result_beat_t;

endpackage

>>> rtl/lpd_msg_if.sv
// ----------------------------------------------------------------------------
// lpd_msg_if
// Valid/ready channel carrying one received message byte per beat.
// ----------------------------------------------------------------------------
interface lpd_msg_if;
  logic              valid;
  logic              ready;
  lpd_pkg::msg_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/lpd_result_if.sv
// ----------------------------------------------------------------------------
// lpd_result_if
// Valid/ready channel carrying one deframer result per beat.
// ----------------------------------------------------------------------------
interface lpd_result_if;
  logic                 valid;
  logic                 ready;
  lpd_pkg::result_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/length_prefixed_pair_deframer_core.sv
// ----------------------------------------------------------------------------
// length_prefixed_pair_deframer_core
// Strips the type/length header of each message, splits the payload into two
// strings at the first zero byte and reports a status on the final byte.
// ----------------------------------------------------------------------------
//
//  Channel   Modport  Beat contents
//  -------   -------  ---------------------------------------------------------
//  msg       sink     rx_byte, end_of_message
//  result    source   data_valid, payload_byte, second_part, message_type,
//                     frame_end, status
//
// One message byte is taken per cycle while the result is not stalled; a byte
// is captured in the input register when accepted and then decoded into the
// result register, from which its result beat is offered. Throughput is set by
// the single decode stage between the two registers. Header bytes and the first
// zero payload byte produce no result beat unless they end the message.
// A stalled result holds the decode stage, and an empty input register still
// takes one more beat. Reset is synchronous and clears all frame state.
// ----------------------------------------------------------------------------
module length_prefixed_pair_deframer_core (
  input  logic                clk,
  input  logic                rst,
  lpd_msg_if.sink             msg,
  lpd_result_if.source        result
);

  localparam logic [lpd_pkg::HdrIdxW-1:0] HdrLast =
    lpd_pkg::HdrIdxW'(lpd_pkg::HeaderBytes);
  localparam logic [lpd_pkg::LenW-1:0] CountMax = '1;

  // Input register
  logic                  in_valid;
  lpd_pkg::msg_beat_t    in_beat;

  // Frame state
  logic [lpd_pkg::HdrIdxW-1:0] header_index;
  logic [lpd_pkg::LenW-1:0]    declared_length;
  logic [lpd_pkg::LenW-1:0]    received_count;
  logic                        separator_seen;
  logic [7:0]                  held_type;

  // Result register
  logic                  out_valid;
  lpd_pkg::result_beat_t out_beat;

  logic                        out_free;
  logic                        advance;
  logic                        in_header;
  logic [lpd_pkg::HdrIdxW-1:0] header_index_next;
  logic [lpd_pkg::LenW-1:0]    declared_length_next;
  logic [lpd_pkg::LenW-1:0]    received_count_next;
  logic                        separator_seen_next;
  logic [7:0]                  held_type_next;
  logic                        emit;
  lpd_pkg::result_beat_t       beat_next;

  assign out_free  = !out_valid || result.ready;
  assign advance   = in_valid && out_free;
  assign msg.ready = !in_valid || advance;

  assign result.valid = out_valid;
  assign result.data  = out_beat;

  always_comb begin
    in_header            = (header_index < HdrLast);
    header_index_next    = header_index;
    declared_length_next = declared_length;
    received_count_next  = received_count;
    separator_seen_next  = separator_seen;
    held_type_next       = held_type;
    beat_next            = '0;

    if (in_header) begin
      if (header_index == '0) begin
        held_type_next = in_beat.rx_byte;
      end else begin
        declared_length_next = {declared_length[lpd_pkg::LenW-9:0], in_beat.rx_byte};
      end
      header_index_next = header_index + 1'b1;
    end else begin
      if (received_count != CountMax) begin
        received_count_next = received_count + 1'b1;
      end
      if (in_beat.rx_byte == 8'h00 && !separator_seen) begin
        separator_seen_next = 1'b1;
      end else begin
        beat_next.data_valid   = 1'b1;
        beat_next.payload_byte = in_beat.rx_byte;
        beat_next.second_part  = separator_seen;
      end
    end

    beat_next.message_type = held_type_next;
    beat_next.frame_end    = in_beat.end_of_message;
    if (in_beat.end_of_message) begin
      // A message whose last byte completes the header is long enough.
      if (header_index_next < HdrLast) begin
        beat_next.status = lpd_pkg::ST_TOO_SHORT;
      end else if (received_count_next != declared_length_next) begin
        beat_next.status = lpd_pkg::ST_LEN_MISMATCH;
      end else if (!separator_seen_next) begin
        beat_next.status = lpd_pkg::ST_NO_SEP;
      end else begin
        beat_next.status = lpd_pkg::ST_OK;
      end
    end

    emit = beat_next.data_valid || in_beat.end_of_message;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid        <= 1'b0;
      out_valid       <= 1'b0;
      header_index    <= '0;
      declared_length <= '0;
      received_count  <= '0;
      separator_seen  <= 1'b0;
      held_type       <= '0;
    end else begin
      if (msg.ready) begin
        in_valid <= msg.valid;
      end
      if (out_free) begin
        out_valid <= advance && emit;
      end
      if (advance) begin
        if (in_beat.end_of_message) begin
          // The final byte closes the frame; the next beat starts a new header.
          header_index    <= '0;
          declared_length <= '0;
          received_count  <= '0;
          separator_seen  <= 1'b0;
          held_type       <= '0;
        end else begin
          header_index    <= header_index_next;
          declared_length <= declared_length_next;
          received_count  <= received_count_next;
          separator_seen  <= separator_seen_next;
          held_type       <= held_type_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (msg.valid && msg.ready) begin
      in_beat <= msg.data;
    end
    if (advance && emit) begin
      out_beat <= beat_next;
    end
  end

  a_frame_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && in_beat.end_of_message) |=>
      (header_index == '0 && received_count == '0 && !separator_seen))
    else $error("frame state not cleared after final byte");

  a_silent_only_at_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_beat.data_valid) |-> out_beat.frame_end)
    else $error("result beat without data outside frame end");

  a_short_has_no_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_beat.frame_end && out_beat.status == lpd_pkg::ST_TOO_SHORT)
      |-> !out_beat.data_valid)
    else $error("too-short frame carried a string byte");

  a_index_bounded: assert property (@(posedge clk) disable iff (rst)
    1'b1 |-> (header_index <= HdrLast))
    else $error("header index beyond header length");

  a_count_after_header: assert property (@(posedge clk) disable iff (rst)
    (received_count != '0) |-> (header_index == HdrLast))
    else $error("payload counted before header complete");

endmodule

>>> dv/length_prefixed_pair_deframer_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// length_prefixed_pair_deframer_core_tb
// Feeds framed messages (type byte, big-endian length, two zero-split
// strings) byte by byte into the deframer and compares every result beat
// with a cycle-free model of the frame parser kept inside a scoreboard.
// ----------------------------------------------------------------------------
module length_prefixed_pair_deframer_core_tb;

  localparam int unsigned TotalBeats = 1650;
  localparam int unsigned CycleLimit = 500000;

  class deframe_scoreboard;
    logic [lpd_pkg::HdrIdxW-1:0] hdr_taken;
    logic [lpd_pkg::LenW-1:0]    length_field;
    logic [lpd_pkg::LenW-1:0]    payload_taken;
    bit                          split_found;
    logic [7:0]                  type_field;
    lpd_pkg::result_beat_t       awaited_results[$];
    int unsigned                 errors;
    int unsigned                 frames_by_status[4];
    int unsigned                 string_bytes;
    int unsigned                 results_compared;

    function void clear_frame();
      hdr_taken     = '0;
      length_field  = '0;
      payload_taken = '0;
      split_found   = 1'b0;
      type_field    = '0;
    endfunction

    function int unsigned outstanding();
      return awaited_results.size();
    endfunction

    // Parses one accepted message byte and queues the result beat it causes.
    function void take_msg_beat(lpd_pkg::msg_beat_t beat);
      lpd_pkg::result_beat_t r;
      r = '0;
      if (hdr_taken < lpd_pkg::HeaderBytes) begin
        if (hdr_taken == 0)
          type_field = beat.rx_byte;
        else
          length_field = {length_field[lpd_pkg::LenW-9:0], beat.rx_byte};
        hdr_taken = hdr_taken + 1'b1;
      end else begin
        if (payload_taken != '1)
          payload_taken = payload_taken + 1'b1;
        if (beat.rx_byte == 8'h00 && !split_found) begin
          split_found = 1'b1;
        end else begin
          r.data_valid   = 1'b1;
          r.payload_byte = beat.rx_byte;
          r.second_part  = split_found;
        end
      end
      if (!r.data_valid && !beat.end_of_message)
        return;
      r.message_type = type_field;
      if (r.data_valid)
        string_bytes++;
      if (beat.end_of_message) begin
        r.frame_end = 1'b1;
        if (hdr_taken < lpd_pkg::HeaderBytes)
          r.status = lpd_pkg::ST_TOO_SHORT;
        else if (payload_taken != length_field)
          r.status = lpd_pkg::ST_LEN_MISMATCH;
        else if (!split_found)
          r.status = lpd_pkg::ST_NO_SEP;
        else
          r.status = lpd_pkg::ST_OK;
        frames_by_status[r.status]++;
        clear_frame();
      end
      awaited_results.insert(awaited_results.size(), r);
    endfunction

    function void compare_field(string field, logic [7:0] expv, logic [7:0] gotv);
      if (gotv !== expv) begin
        $error("%s: expected %0h, got %0h", field, expv, gotv);
        errors++;
      end
    endfunction

    function void check_result(lpd_pkg::result_beat_t got);
      lpd_pkg::result_beat_t exp;
      if (awaited_results.size() == 0) begin
        $error("result beat with nothing expected: byte %0h frame_end %0b status %0d",
               got.payload_byte, got.frame_end, got.status);
        errors++;
        return;
      end
      exp = awaited_results.pop_front();
      results_compared++;
      compare_field("data_valid", {7'd0, exp.data_valid}, {7'd0, got.data_valid});
      compare_field("payload_byte", exp.payload_byte, got.payload_byte);
      compare_field("second_part", {7'd0, exp.second_part}, {7'd0, got.second_part});
      compare_field("message_type", exp.message_type, got.message_type);
      compare_field("frame_end", {7'd0, exp.frame_end}, {7'd0, got.frame_end});
      compare_field("status", {6'd0, exp.status}, {6'd0, got.status});
    endfunction
  endclass

  logic clk;
  logic rst;

  lpd_msg_if    msg ();
  lpd_result_if result ();

  length_prefixed_pair_deframer_core dut (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg),
    .result (result)
  );

  deframe_scoreboard sb = new();

  logic [7:0]  frame_q[$];
  logic [7:0]  payload_q[$];
  int unsigned beats_sent;
  int unsigned cycle_count;
  bit          src_no_idle;
  bit          sink_no_idle;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("length_prefixed_pair_deframer_core_tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (msg.valid && msg.ready)
        sb.take_msg_beat(msg.data);
      if (result.valid && result.ready)
        sb.check_result(result.data);
    end
  end

  // Now and then a side flips into a stretch where it never idles.
  function automatic int unsigned draw_gap(inout bit no_idle);
    if ($urandom_range(0, 31) == 0)
      no_idle = !no_idle;
    if (no_idle)
      return 0;
    return $urandom_range(0, 12);
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] rand_nonzero_byte();
    if ($urandom_range(0, 7) == 0)
      return 8'hFF;
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [7:0] rand_zero_heavy_byte();
    if ($urandom_range(0, 3) == 0)
      return 8'h00;
    return rand_byte();
  endfunction

  // Mostly short strings, with an occasional long one.
  function automatic int unsigned draw_str_len();
    if ($urandom_range(0, 15) == 0)
      return $urandom_range(0, 40);
    return $urandom_range(0, 6);
  endfunction

  function automatic void build_payload(bit with_split);
    int unsigned n;
    payload_q.delete();
    n = draw_str_len();
    repeat (n) payload_q.insert(payload_q.size(), rand_nonzero_byte());
    if (with_split) begin
      payload_q.insert(payload_q.size(), 8'h00);
      n = draw_str_len();
      repeat (n) payload_q.insert(payload_q.size(), rand_zero_heavy_byte());
    end
  endfunction

  function automatic void frame_from_payload(logic [7:0] type_byte, logic [31:0] len);
    frame_q.delete();
    frame_q.insert(frame_q.size(), type_byte);
    for (int k = 3; k >= 0; k--)
      frame_q.insert(frame_q.size(), len[8*k +: 8]);
    foreach (payload_q[i])
      frame_q.insert(frame_q.size(), payload_q[i]);
  endfunction

  function automatic void build_random_frame();
    int unsigned pick;
    int unsigned n;
    logic [31:0] len;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      build_payload(1'b1);
      frame_from_payload(rand_byte(), payload_q.size());
    end else if (pick < 70) begin
      // Message cut off inside the header.
      frame_q.delete();
      n = $urandom_range(1, 4);
      repeat (n) frame_q.insert(frame_q.size(), rand_byte());
    end else if (pick < 80) begin
      build_payload(1'($urandom_range(0, 1)));
      len = payload_q.size();
      case ($urandom_range(0, 2))
        0: len = len + $urandom_range(1, 3);
        1: len = (len == 0) ? 32'hFFFF_FFFF : len - 1;
        default: len = $urandom;
      endcase
      frame_from_payload(rand_byte(), len);
    end else if (pick < 90) begin
      build_payload(1'b0);
      frame_from_payload(rand_byte(), payload_q.size());
    end else begin
      frame_q.delete();
      n = $urandom_range(1, 20);
      repeat (n) frame_q.insert(frame_q.size(), rand_zero_heavy_byte());
    end
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic eom);
    int unsigned gap;
    gap = draw_gap(src_no_idle);
    if (gap != 0) begin
      msg.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg.valid <= 1'b1;
    msg.data  <= {b, eom};
    do @(posedge clk); while (!msg.ready);
    beats_sent++;
  endtask

  task automatic send_frame();
    int unsigned last;
    last = frame_q.size() - 1;
    foreach (frame_q[i])
      send_beat(frame_q[i], i == last);
  endtask

  task automatic drain_results();
    msg.valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  initial begin
    int unsigned gap;
    result.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      gap = draw_gap(sink_no_idle);
      if (gap != 0) begin
        result.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result.ready <= 1'b1;
      do @(posedge clk); while (!result.valid);
    end
  end

  initial begin
    int unsigned frames;
    rst       <= 1'b1;
    msg.valid <= 1'b0;
    msg.data  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Single byte: ends inside the header.
    frame_q = '{8'hFF};
    send_frame();
    // Header only with zero length: final beat is a silent header byte.
    frame_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_frame();
    // Leading separator, then a one-byte second string ending the frame.
    frame_q = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'hFF};
    send_frame();
    // Maximum declared length, frame ends on the separator itself.
    frame_q = '{8'h5A, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
    send_frame();
    // Length matches but the payload never holds a zero.
    frame_q = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h01, 8'h41};
    send_frame();
    drain_results();

    frames = 0;
    while (beats_sent < TotalBeats) begin
      build_random_frame();
      send_frame();
      frames++;
      if (frames % 16 == 0)
        drain_results();
    end
    drain_results();
    repeat (20) @(posedge clk);

    $display("Sent %0d message beats; frames ok %0d, too short %0d,",
             beats_sent, sb.frames_by_status[lpd_pkg::ST_OK],
             sb.frames_by_status[lpd_pkg::ST_TOO_SHORT]);
    $display("length mismatch %0d, no separator %0d; compared %0d result beats, %0d with data.",
             sb.frames_by_status[lpd_pkg::ST_LEN_MISMATCH],
             sb.frames_by_status[lpd_pkg::ST_NO_SEP],
             sb.results_compared, sb.string_bytes);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("length_prefixed_pair_deframer_core_tb: clean");
    end else begin
      $display("length_prefixed_pair_deframer_core_tb: errors");
    end
    $finish;
  end

endmodule
